// File: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising edge of clk, off while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on the rising edge of clk, off while in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// File: hw/rtl/jhk_pkg.sv
// ----------------------------------------------------------------------------
// jhk_pkg
// types and codes for the joystick hysteresis key mapper
// ----------------------------------------------------------------------------
package jhk_pkg;

	localparam int unsigned LEVEL_W  = 10;
	localparam int unsigned MARGIN_W = 9;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_CENTER       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENGAGE_MARGIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MARGIN = 2'd3;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_NONE     = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_MENU     = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_KEYBOARD = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_VOL_UP   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_VOL_DOWN = 3'd4;

	// reset values of the configuration registers
	localparam logic [LEVEL_W-1:0]  X_CENTER_RST       = 10'd512;
	localparam logic [LEVEL_W-1:0]  Y_CENTER_RST       = 10'd512;
	localparam logic [MARGIN_W-1:0] ENGAGE_MARGIN_RST  = 9'd120;
	localparam logic [MARGIN_W-1:0] RELEASE_MARGIN_RST = 9'd100;

	typedef struct packed {
		logic [LEVEL_W-1:0] x_level;
		logic [LEVEL_W-1:0] y_level;
		logic               fire_button;
		logic               autofire_button;
		logic               aux_button;
	} jhk_in_t;

	typedef struct packed {
		logic                left_held;
		logic                right_held;
		logic                up_held;
		logic                down_held;
		logic                fire_held;
		logic                autofire_held;
		logic                send_report;
		logic [ACTION_W-1:0] action;
	} jhk_out_t;

endpackage

// File: hw/rtl/joystick_hysteresis_keymap.sv
// ----------------------------------------------------------------------------
// joystick_hysteresis_keymap: stick and button poll to key bits and actions
// an accepted poll is held in the input reg, then its result in the result reg
// throughput one poll per cycle, ready falls only when the result is stalled
// async reset clears pipeline, directions, aux history, chord requests and
// restores the config defaults
// ----------------------------------------------------------------------------
module joystick_hysteresis_keymap (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  jhk_pkg::jhk_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output jhk_pkg::jhk_out_t               out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jhk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jhk_pkg::LEVEL_W-1:0]     cfg_data
);
	import jhk_pkg::*;
	`include "assert_macros.svh"

	// configuration
	logic [LEVEL_W-1:0]  x_center_q;
	logic [LEVEL_W-1:0]  y_center_q;
	logic [MARGIN_W-1:0] engage_margin_q;
	logic [MARGIN_W-1:0] release_margin_q;

	// pipeline and state
	logic                valid_s1;
	jhk_in_t             data_s1;
	logic                valid_s2;
	jhk_out_t            data_s2;
	logic [3:0]          dir_q;    // left, right, up, down at bits 0..3
	logic                aux_prev_q;
	logic [2:0]          chord_q;  // keyboard, volume up, volume down at bits 0..2

	logic                advance;
	logic                aux_press;
	logic                aux_release;
	logic [2:0]          chord_next;
	logic [ACTION_W-1:0] action;
	logic [3:0]          dir_mid;
	logic [MARGIN_W-1:0] m_left;
	logic [MARGIN_W-1:0] m_right;
	logic [MARGIN_W-1:0] m_up;
	logic [MARGIN_W-1:0] m_down;
	logic [LEVEL_W:0]    x_ext;
	logic [LEVEL_W:0]    y_ext;
	logic [LEVEL_W:0]    xc_ext;
	logic [LEVEL_W:0]    yc_ext;
	logic [3:0]          dir_next;
	jhk_out_t            result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_center_q       <= X_CENTER_RST;
			y_center_q       <= Y_CENTER_RST;
			engage_margin_q  <= ENGAGE_MARGIN_RST;
			release_margin_q <= RELEASE_MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_CENTER:       x_center_q       <= cfg_data;
				REG_Y_CENTER:       y_center_q       <= cfg_data;
				REG_ENGAGE_MARGIN:  engage_margin_q  <= cfg_data[MARGIN_W-1:0];
				REG_RELEASE_MARGIN: release_margin_q <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// aux edge handling
	assign aux_press   = data_s1.aux_button && !aux_prev_q;
	assign aux_release = !data_s1.aux_button && aux_prev_q;

	always_comb begin
		chord_next = chord_q;
		action     = ACT_NONE;
		dir_mid    = dir_q;
		if (aux_press) begin
			chord_next = {dir_q[3], dir_q[2], dir_q[0]};
		end
		if (aux_release) begin
			chord_next = 3'b000;
			if (chord_q[0]) begin
				action  = ACT_KEYBOARD;
				dir_mid = 4'b0000;
			end else if (chord_q[1]) begin
				action = ACT_VOL_UP;
			end else if (chord_q[2]) begin
				action = ACT_VOL_DOWN;
			end else begin
				action  = ACT_MENU;
				dir_mid = 4'b0000;
			end
		end
	end

	// hysteresis: release margin while held, engage margin while released
	assign m_left  = dir_mid[0] ? release_margin_q : engage_margin_q;
	assign m_right = dir_mid[1] ? release_margin_q : engage_margin_q;
	assign m_up    = dir_mid[2] ? release_margin_q : engage_margin_q;
	assign m_down  = dir_mid[3] ? release_margin_q : engage_margin_q;

	assign x_ext  = {1'b0, data_s1.x_level};
	assign y_ext  = {1'b0, data_s1.y_level};
	assign xc_ext = {1'b0, x_center_q};
	assign yc_ext = {1'b0, y_center_q};

	// level < center - m rewritten as level + m < center, all unsigned
	assign dir_next[0] = (x_ext + {2'b00, m_left}) < xc_ext;
	assign dir_next[1] = x_ext > (xc_ext + {2'b00, m_right});
	assign dir_next[2] = (y_ext + {2'b00, m_up}) < yc_ext;
	assign dir_next[3] = y_ext > (yc_ext + {2'b00, m_down});

	always_comb begin
		result.left_held     = dir_next[0];
		result.right_held    = dir_next[1];
		result.up_held       = dir_next[2];
		result.down_held     = dir_next[3];
		result.fire_held     = data_s1.fire_button;
		result.autofire_held = data_s1.autofire_button;
		result.send_report   = (|dir_next) || data_s1.fire_button
			|| data_s1.autofire_button;
		result.action        = action;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			dir_q      <= 4'b0000;
			aux_prev_q <= 1'b0;
			chord_q    <= 3'b000;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2   <= 1'b1;
				dir_q      <= dir_next;
				aux_prev_q <= data_s1.aux_button;
				chord_q    <= chord_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	`ASSERT_CLK(a_no_action_without_release,
		(advance && !data_s1.aux_button && !aux_prev_q) |=> (data_s2.action == ACT_NONE),
		"action produced without aux release")
	`ASSERT_CLK(a_chord_cleared_on_release,
		(advance && aux_release) |=> (chord_q == 3'b000),
		"chord requests kept after aux release")
	`ASSERT_CLK(a_stalled_item_kept,
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1)),
		"input stage lost a stalled item")
	`ASSERT_IMPL(a_menu_clears_held,
		valid_s1 && aux_release && !chord_q[0] && !chord_q[1] && !chord_q[2],
		action == ACT_MENU && dir_mid == 4'b0000,
		"menu action did not clear held directions")

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: joystick hysteresis key mapper
// polls with stick levels and buttons are sent in bursts against a stalling
// receiver; each key report is checked field by field against a typed result or a predictor
// that keeps its own hysteresis, aux chord state and calibration
// ----------------------------------------------------------------------------
module testbench;
	import jhk_pkg::*;

	typedef struct {
		jhk_in_t  poll;
		bit       typed;
		jhk_out_t res;
	} poll_row_t;

	typedef struct {
		logic [LEVEL_W-1:0]  xc;
		logic [LEVEL_W-1:0]  yc;
		logic [MARGIN_W-1:0] eng;
		logic [MARGIN_W-1:0] rel;
	} calib_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_t;

	localparam int PERIOD     = 20;
	localparam int PHASE_POLLS = 270;
	localparam int HOLD_OFF   = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	jhk_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	jhk_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_X_CENTER;
	logic [LEVEL_W-1:0] cfg_data = '0;

	// predictor state and calibration
	logic [LEVEL_W-1:0]  cal_x = X_CENTER_RST;
	logic [LEVEL_W-1:0]  cal_y = Y_CENTER_RST;
	logic [MARGIN_W-1:0] m_engage = ENGAGE_MARGIN_RST;
	logic [MARGIN_W-1:0] m_release = RELEASE_MARGIN_RST;
	logic [3:0] held_dirs = '0;  // left, right, up, down from bit 0
	logic       aux_seen = 1'b0;
	logic [2:0] chord_req = '0;  // keyboard, volume up, volume down from bit 0

	jhk_out_t want_reports[$];
	poll_row_t rows[$];
	int errors = 0;
	bit stall_req = 1'b0;
	bit stall_done = 1'b0;

	joystick_hysteresis_keymap dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(PERIOD/2) clk = ~clk;

	function automatic jhk_out_t poll_keys(input jhk_in_t p);
		jhk_out_t r;
		logic [3:0] dirs;
		int x, y, xc, yc, ml, mr, mu, md;
		r = '0;
		r.action = ACT_NONE;
		if (p.aux_button && !aux_seen)
			chord_req = {held_dirs[3], held_dirs[2], held_dirs[0]};
		if (!p.aux_button && aux_seen) begin
			if (chord_req[0]) begin
				r.action = ACT_KEYBOARD;
				held_dirs = '0;
			end else if (chord_req[1]) begin
				r.action = ACT_VOL_UP;
			end else if (chord_req[2]) begin
				r.action = ACT_VOL_DOWN;
			end else begin
				r.action = ACT_MENU;
				held_dirs = '0;
			end
			chord_req = '0;
		end
		aux_seen = p.aux_button;
		x = p.x_level;
		y = p.y_level;
		xc = cal_x;
		yc = cal_y;
		ml = held_dirs[0] ? m_release : m_engage;
		mr = held_dirs[1] ? m_release : m_engage;
		mu = held_dirs[2] ? m_release : m_engage;
		md = held_dirs[3] ? m_release : m_engage;
		dirs[0] = x < xc - ml;
		dirs[1] = x > xc + mr;
		dirs[2] = y < yc - mu;
		dirs[3] = y > yc + md;
		held_dirs = dirs;
		r.left_held = dirs[0];
		r.right_held = dirs[1];
		r.up_held = dirs[2];
		r.down_held = dirs[3];
		r.fire_held = p.fire_button;
		r.autofire_held = p.autofire_button;
		r.send_report = (dirs != 0) || p.fire_button || p.autofire_button;
		return r;
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level(input int c);
		int v, m;
		case ($urandom_range(0, 9))
			0, 1, 2: v = int'($urandom_range(0, 1023));
			3, 4, 5, 6: begin
				m = $urandom_range(0, 1) ? int'(m_engage) : int'(m_release);
				v = $urandom_range(0, 1) ? c + m : c - m;
				v = v + int'($urandom_range(0, 4)) - 2;
			end
			7: v = $urandom_range(0, 1) ? 1023 : 0;
			default: v = c + int'($urandom_range(0, 60)) - 30;
		endcase
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[LEVEL_W-1:0];
	endfunction

	function automatic poll_row_t row(input int x, input int y, input bit f, input bit af,
		input bit aux, input bit typed, input jhk_out_t res);
		poll_row_t r;
		r.poll.x_level = x[LEVEL_W-1:0];
		r.poll.y_level = y[LEVEL_W-1:0];
		r.poll.fire_button = f;
		r.poll.autofire_button = af;
		r.poll.aux_button = aux;
		r.typed = typed;
		r.res = res;
		return r;
	endfunction

	// valid is left high; the caller lowers it when a gap follows
	task automatic offer(input jhk_in_t p, input bit typed, input jhk_out_t res);
		jhk_out_t pred;
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = poll_keys(p);
		want_reports.push_back(typed ? res : pred);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_X_CENTER: cal_x = val;
			REG_Y_CENTER: cal_y = val;
			REG_ENGAGE_MARGIN: m_engage = val[MARGIN_W-1:0];
			REG_RELEASE_MARGIN: m_release = val[MARGIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (want_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic mismatch(input string field, input int want, input int got);
		$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin : report_check
		jhk_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (want_reports.size() == 0) begin
				$display("%0t: report with no poll waiting, expected none actual %h",
					$time, out_data);
				errors++;
			end else begin
				want = want_reports.pop_front();
				if (out_data.left_held !== want.left_held)
					mismatch("left_held", want.left_held, out_data.left_held);
				if (out_data.right_held !== want.right_held)
					mismatch("right_held", want.right_held, out_data.right_held);
				if (out_data.up_held !== want.up_held)
					mismatch("up_held", want.up_held, out_data.up_held);
				if (out_data.down_held !== want.down_held)
					mismatch("down_held", want.down_held, out_data.down_held);
				if (out_data.fire_held !== want.fire_held)
					mismatch("fire_held", want.fire_held, out_data.fire_held);
				if (out_data.autofire_held !== want.autofire_held)
					mismatch("autofire_held", want.autofire_held, out_data.autofire_held);
				if (out_data.send_report !== want.send_report)
					mismatch("send_report", want.send_report, out_data.send_report);
				if (out_data.action !== want.action)
					mismatch("action", want.action, out_data.action);
			end
		end
	end

	// receiver stalls, with one long hold-off on request
	initial begin : receiver
		int seg, cyc;
		rx_mode_t mode;
		cyc = 0;
		forever begin
			seg = $urandom_range(10, 150);
			mode = rx_mode_t'($urandom_range(0, 3));
			repeat (seg) begin
				@(posedge clk);
				cyc++;
				if (stall_req && !stall_done) begin
					out_ready <= 1'b0;
					repeat (HOLD_OFF) @(posedge clk);
					stall_done = 1'b1;
				end
				case (mode)
					RX_OPEN: out_ready <= 1'b1;
					RX_COIN: out_ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: out_ready <= (cyc % 4) != 3;
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		calib_t phases[6];
		jhk_in_t p;
		logic aux_lvl;
		int sent, burst, gap;

		phases[0] = '{10'd300, 10'd700, 9'd50, 9'd80};
		phases[1] = '{10'd0, 10'd1023, 9'd0, 9'd0};
		phases[2] = '{10'd1023, 10'd0, 9'd511, 9'd511};
		phases[3] = '{10'd512, 10'd512, 9'd511, 9'd0};
		phases[4] = '{10'd100, 10'd900, 9'd200, 9'd30};
		phases[5] = '{10'd512, 10'd512, 9'd120, 9'd100};

		// directed polls at reset calibration: engage 392/632, release 412/612
		rows.push_back(row(512, 512, 0, 0, 0, 1,
			jhk_out_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ACT_NONE}));
		rows.push_back(row(0, 0, 1, 0, 0, 1,
			jhk_out_t'{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, ACT_NONE}));
		rows.push_back(row(1023, 1023, 0, 1, 0, 1,
			jhk_out_t'{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, ACT_NONE}));
		rows.push_back(row(632, 512, 0, 0, 0, 0, '0));
		rows.push_back(row(612, 512, 0, 0, 0, 0, '0));
		rows.push_back(row(632, 512, 0, 0, 0, 0, '0));
		rows.push_back(row(633, 392, 0, 0, 0, 0, '0));
		rows.push_back(row(391, 391, 0, 0, 0, 0, '0));
		rows.push_back(row(411, 411, 0, 0, 0, 0, '0));
		rows.push_back(row(412, 412, 0, 0, 0, 0, '0));
		// aux alone gives the menu
		rows.push_back(row(512, 512, 0, 0, 1, 0, '0));
		rows.push_back(row(512, 512, 0, 0, 0, 1,
			jhk_out_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ACT_MENU}));
		// left and up chord: keyboard wins and clears the held directions
		rows.push_back(row(0, 0, 0, 0, 0, 0, '0));
		rows.push_back(row(400, 400, 0, 0, 1, 0, '0));
		rows.push_back(row(400, 400, 0, 0, 0, 0, '0));
		// volume up keeps the held direction
		rows.push_back(row(512, 0, 0, 0, 0, 0, '0));
		rows.push_back(row(512, 0, 0, 0, 1, 0, '0));
		rows.push_back(row(512, 0, 0, 0, 0, 0, '0));
		// volume down
		rows.push_back(row(512, 1023, 0, 0, 0, 0, '0));
		rows.push_back(row(512, 1023, 0, 0, 1, 0, '0));
		rows.push_back(row(512, 1023, 0, 0, 0, 0, '0));
		// chord taken at the press, not while aux is held
		rows.push_back(row(1023, 512, 1, 0, 1, 0, '0));
		rows.push_back(row(0, 512, 0, 0, 1, 0, '0));
		rows.push_back(row(512, 512, 0, 0, 0, 0, '0));
		rows.push_back(row(512, 512, 1, 1, 0, 1,
			jhk_out_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, ACT_NONE}));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			offer(rows[i].poll, rows[i].typed, rows[i].res);
		drain();

		aux_lvl = 1'b0;
		for (int ph = 0; ph <= 6; ph++) begin
			if (ph > 0) begin
				write_reg(REG_X_CENTER, phases[ph-1].xc);
				write_reg(REG_Y_CENTER, phases[ph-1].yc);
				write_reg(REG_ENGAGE_MARGIN, {1'b0, phases[ph-1].eng});
				write_reg(REG_RELEASE_MARGIN, {1'b0, phases[ph-1].rel});
				cfg_valid <= 1'b0;
				@(posedge clk);
			end
			if (ph == 1)
				stall_req = 1'b1;
			sent = 0;
			while (sent < PHASE_POLLS) begin
				burst = $urandom_range(1, 24);
				repeat (burst) begin
					if ($urandom_range(0, 4) == 0)
						aux_lvl = ~aux_lvl;
					p.x_level = pick_level(cal_x);
					p.y_level = pick_level(cal_y);
					p.fire_button = 1'($urandom_range(0, 1));
					p.autofire_button = 1'($urandom_range(0, 1));
					p.aux_button = aux_lvl;
					offer(p, 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 3) != 0) begin
					gap = $urandom_range(1, 6);
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#(PERIOD * 200000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
